[hw/rtl/tsbw_pkg.sv]
`timescale 1ns / 1ps

package tsbw_pkg;

	localparam int TSBW_TEXEL_CAPACITY  = 65536;
	localparam int TSBW_COORD_FRAC_BITS = 16;

	localparam int SIZE_W  = 11;
	localparam int INDEX_W = 16;
	localparam int CHAN_W  = 8;
	localparam int COORD_W = 24;
	localparam int MODE_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

	localparam logic [MODE_W-1:0] MODE_WRITE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_NEAREST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BILINEAR = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

endpackage

[hw/rtl/tsbw_ram.sv]
`timescale 1ns / 1ps

module tsbw_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/texture_sampler_bilinear_wrap_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser: mode; tdata: index, rgb, u, v
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: out_red, out_green, out_blue
// cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// Flow: one input transaction at a time; s_axis_tready is high only in idle.
// A shared restoring modulo unit wraps column and row on a DW-bit dividend (DW = 27 at
// default parameters); one shared multiplier serves scaling, addressing and blending.
// Store index wraps by dropping upper bits (capacity is a power of two).
// Reset clears control state and the size registers (256 x 256); the texel
// store is not cleared. A stalled result holds in the output register; the
// next finished sample waits until that register is free.

module texture_sampler_bilinear_wrap_top #(
	parameter int TEXEL_CAPACITY  = tsbw_pkg::TSBW_TEXEL_CAPACITY,
	parameter int COORD_FRAC_BITS = tsbw_pkg::TSBW_COORD_FRAC_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// texel_index[15:0], red_in[23:16], green_in[31:24], blue_in[39:32],
	// u_coord[63:40], v_coord[87:64]
	input  logic [87:0]                        s_axis_tdata,
	// mode[1:0]
	input  logic [tsbw_pkg::MODE_W-1:0]        s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic [23:0]                        m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [tsbw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsbw_pkg::SIZE_W-1:0]        cfg_data
);

	import tsbw_pkg::*;

	localparam int FB    = COORD_FRAC_BITS;
	localparam int AW    = $clog2(TEXEL_CAPACITY);
	localparam int MA    = (COORD_W > FB + 9) ? COORD_W : FB + 9;   // signed A operand
	localparam int MB    = (SIZE_W > FB + 1) ? SIZE_W : FB + 1;     // unsigned B operand
	localparam int PW    = MA + MB + 1;                             // product
	localparam int DW    = (PW - FB > 24) ? PW - FB : 24;           // modulo dividend
	localparam int DVW   = SIZE_W;                                  // modulo divisor
	localparam int CW    = $clog2(DW);
	localparam int WW    = FB + 1;                                  // weight
	localparam int ACW   = 2 * FB + 9;                              // blend accumulator

	localparam logic [PW-1:0]  HALF   = PW'(1) << (FB - 1);
	localparam logic [PW-1:0]  FMASK  = (PW'(1) << FB) - PW'(1);
	localparam logic [WW-1:0]  ONE    = WW'(1) << FB;
	localparam logic [ACW-1:0] HALF2  = ACW'(1) << (2 * FB - 1);
	localparam logic [ACW-1:0] ACCMAX = ACW'(255) << (2 * FB);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_MULX   = 12'b0000_0000_0010,
		S_MULY   = 12'b0000_0000_0100,
		S_PREP   = 12'b0000_0000_1000,
		S_MOD    = 12'b0000_0001_0000,
		S_WR     = 12'b0000_0010_0000,
		S_IDXMUL = 12'b0000_0100_0000,
		S_IDXADD = 12'b0000_1000_0000,
		S_RD     = 12'b0001_0000_0000,
		S_RDW    = 12'b0010_0000_0000,
		S_BLEND  = 12'b0100_0000_0000,
		S_OUT    = 12'b1000_0000_0000
	} state_t;

	typedef enum logic {
		T_COL,
		T_ROW
	} mod_tgt_t;

	state_t   state_q;
	mod_tgt_t tgt_q;

	logic [SIZE_W-1:0]  w_q, h_q, w_eff, h_eff;
	logic               bil_q;
	logic [23:0]        wdata_q;
	logic signed [COORD_W-1:0] u_q, v_q;

	// shared multiplier
	logic signed [MA-1:0] mul_a;
	logic [MB-1:0]        mul_b;
	logic signed [MB:0]   mul_bs;
	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] sx_q;

	// shared modulo unit
	logic [DW-1:0]  mag_q;
	logic [DVW-1:0] rem_q, div_q;
	logic           neg_q;
	logic [CW-1:0]  cnt_q;
	logic [DVW:0]   rem_sh, rem_sub;
	logic [DVW-1:0] rem_nx, mod_res;

	// coordinate preparation
	logic [PW-1:0] sxa, sya, sx_add, sy_add;
	logic [DW-1:0] magx, magy, ym_q;
	logic          yneg_q;
	logic          fxnz_q, fynz_q;
	logic [WW-1:0] wxf_q, wyf_q, wxc, wyc;
	logic [FB-1:0] fx, fy;

	logic [SIZE_W-1:0] colf_q, colc_q, rowf_q, rowc_q;
	logic [SIZE_W-1:0] col_k, row_k, colc_nx, rowc_nx;
	logic [WW-1:0]     wx_k, wy_k;
	logic [1:0]        k_q;
	logic [2:0]        ph_q;

	logic [AW-1:0]  addr_q;
	logic           ram_we;
	logic [23:0]    ram_rdata, texel_q;
	logic [CHAN_W-1:0] chan_sel;

	logic [ACW-1:0] acc_q [3];
	logic [ACW-1:0] acc_rnd [3];
	logic [CHAN_W-1:0] blend_ch [3];

	logic        mvalid_q;
	logic [23:0] mdata_q, res_data;
	logic        out_free;

	// ---------------------------------------------------------------- sizes
	assign w_eff = (w_q == '0) ? SIZE_W'(1) : w_q;
	assign h_eff = (h_q == '0) ? SIZE_W'(1) : h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= SIZE_RESET;
			h_q <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TEX_WIDTH:  w_q <= cfg_data;
				REG_TEX_HEIGHT: h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// --------------------------------------------------- per-fetch selects
	assign wxc   = ONE - wxf_q;
	assign wyc   = ONE - wyf_q;
	// fetch order: (cf,rf) (cf,rc) (cc,rf) (cc,rc)
	assign col_k = k_q[1] ? colc_q : colf_q;
	assign row_k = k_q[0] ? rowc_q : rowf_q;
	assign wx_k  = k_q[1] ? wxc : wxf_q;
	assign wy_k  = k_q[0] ? wyc : wyf_q;

	always_comb begin
		case (ph_q[2:1])
			2'd0:    chan_sel = texel_q[7:0];
			2'd1:    chan_sel = texel_q[15:8];
			default: chan_sel = texel_q[23:16];
		endcase
	end

	// ---------------------------------------------------- multiplier mux
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULX: begin
				mul_a = MA'(u_q);
				mul_b = MB'(w_eff);
			end
			S_MULY: begin
				mul_a = MA'(v_q);
				mul_b = MB'(h_eff);
			end
			S_IDXMUL: begin
				mul_a = MA'($signed({1'b0, row_k}));
				mul_b = MB'(w_eff);
			end
			S_BLEND: begin
				if (ph_q[0]) begin
					// second step: (chan * wy) * wx
					mul_a = prod_s1[MA-1:0];
					mul_b = MB'(wx_k);
				end else begin
					mul_a = MA'($signed({1'b0, chan_sel}));
					mul_b = MB'(wy_k);
				end
			end
			default: ;
		endcase
	end

	assign mul_bs = $signed({1'b0, mul_b});

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_bs;
	end

	// ----------------------------------------------------- modulo step
	always_comb begin
		rem_sh  = {rem_q, mag_q[DW-1]};
		rem_sub = rem_sh - {1'b0, div_q};
		rem_nx  = (rem_sh >= {1'b0, div_q}) ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
		// negative dividend: mathematical modulo
		mod_res = (neg_q && rem_nx != '0) ? div_q - rem_nx : rem_nx;
	end

	// ------------------------------------------------ coordinate prep
	always_comb begin
		sxa    = sx_q[PW-1] ? PW'(-sx_q) : PW'(sx_q);
		sya    = prod_s1[PW-1] ? PW'(-prod_s1) : PW'(prod_s1);
		// nearest rounds half away from zero; bilinear takes the floor
		sx_add = bil_q ? (sx_q[PW-1] ? FMASK : '0) : HALF;
		sy_add = bil_q ? (prod_s1[PW-1] ? FMASK : '0) : HALF;
		magx   = DW'((sxa + sx_add) >> FB);
		magy   = DW'((sya + sy_add) >> FB);
		fx     = sx_q[FB-1:0];
		fy     = prod_s1[FB-1:0];
	end

	// neighbor column / row after the floor results are known
	always_comb begin
		colc_nx = colf_q;
		if (fxnz_q) begin
			colc_nx = (colf_q + SIZE_W'(1) == w_eff) ? '0 : colf_q + SIZE_W'(1);
		end
		rowc_nx = mod_res[SIZE_W-1:0];
		if (fynz_q) begin
			rowc_nx = (mod_res[SIZE_W-1:0] == '0) ? h_eff - SIZE_W'(1)
			                                      : mod_res[SIZE_W-1:0] - SIZE_W'(1);
		end
	end

	// ------------------------------------------------------ result format
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_rnd[c]  = (acc_q[c] + HALF2) >> (2 * FB);
			blend_ch[c] = (acc_rnd[c] > ACW'(255)) ? CHAN_W'(255) : acc_rnd[c][CHAN_W-1:0];
		end
		res_data = bil_q ? {blend_ch[2], blend_ch[1], blend_ch[0]} : texel_q;
	end

	assign out_free = !mvalid_q || m_axis_tready;

	// --------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tgt_q   <= T_COL;
			cnt_q   <= '0;
			k_q     <= '0;
			ph_q    <= '0;
			bil_q   <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				acc_q[c] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						wdata_q <= s_axis_tdata[39:16];
						u_q     <= s_axis_tdata[63:40];
						v_q     <= s_axis_tdata[87:64];
						bil_q   <= (s_axis_tuser == MODE_BILINEAR);
						case (s_axis_tuser)
							MODE_WRITE: begin
								// power-of-two capacity: upper index bits wrap away
								addr_q  <= AW'(s_axis_tdata[INDEX_W-1:0]);
								state_q <= S_WR;
							end
							MODE_NEAREST, MODE_BILINEAR: state_q <= S_MULX;
							default: ;
						endcase
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: begin
					sx_q    <= prod_s1;
					state_q <= S_PREP;
				end
				S_PREP: begin
					fxnz_q  <= (fx != '0);
					fynz_q  <= (fy != '0);
					wxf_q   <= (fx != '0) ? ONE - WW'(fx) : '0;
					wyf_q   <= (fy != '0) ? ONE - WW'(fy) : '0;
					ym_q    <= magy;
					yneg_q  <= !prod_s1[PW-1];
					mag_q   <= magx;
					neg_q   <= sx_q[PW-1];
					rem_q   <= '0;
					div_q   <= DVW'(w_eff);
					cnt_q   <= CW'(DW - 1);
					tgt_q   <= T_COL;
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (cnt_q == '0) begin
						case (tgt_q)
							T_COL: begin
								colf_q <= mod_res[SIZE_W-1:0];
								mag_q  <= ym_q;
								neg_q  <= yneg_q;
								rem_q  <= '0;
								div_q  <= DVW'(h_eff);
								cnt_q  <= CW'(DW - 1);
								tgt_q  <= T_ROW;
							end
							default: begin
								rowf_q  <= mod_res[SIZE_W-1:0];
								rowc_q  <= rowc_nx;
								colc_q  <= colc_nx;
								k_q     <= '0;
								for (int c = 0; c < 3; c++) begin
									acc_q[c] <= '0;
								end
								state_q <= S_IDXMUL;
							end
						endcase
					end else begin
						rem_q <= rem_nx;
						mag_q <= {mag_q[DW-2:0], 1'b0};
						cnt_q <= cnt_q - CW'(1);
					end
				end
				S_WR: state_q <= S_IDLE;
				S_IDXMUL: state_q <= S_IDXADD;
				S_IDXADD: begin
					addr_q  <= AW'(prod_s1[DW-1:0] + DW'(col_k));
					state_q <= S_RD;
				end
				S_RD: state_q <= S_RDW;
				S_RDW: begin
					texel_q <= ram_rdata;
					ph_q    <= '0;
					state_q <= bil_q ? S_BLEND : S_OUT;
				end
				S_BLEND: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd2: acc_q[0] <= acc_q[0] + prod_s1[ACW-1:0];
						3'd4: acc_q[1] <= acc_q[1] + prod_s1[ACW-1:0];
						3'd6: acc_q[2] <= acc_q[2] + prod_s1[ACW-1:0];
						default: ;
					endcase
					if (ph_q == 3'd6) begin
						if (k_q == 2'd3) begin
							state_q <= S_OUT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_IDXMUL;
						end
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------- output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (state_q == S_OUT && out_free) begin
			mvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			mdata_q <= res_data;
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = mvalid_q;
	assign m_axis_tdata  = mdata_q;
	assign ram_we        = (state_q == S_WR);

	// texel store: red [7:0], green [15:8], blue [23:16]
	tsbw_ram #(
		.WIDTH (24),
		.DEPTH (TEXEL_CAPACITY)
	) u_texel_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (wdata_q),
		.raddr (addr_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------- assertions
	a_mod_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MOD) |-> (rem_q < div_q))
		else $error("modulo remainder not below divisor");

	a_nearest_single_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDW && !bil_q) |-> (k_q == 2'd0))
		else $error("nearest sample fetched more than one texel");

	a_acc_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_q[0] <= ACCMAX) && (acc_q[1] <= ACCMAX) && (acc_q[2] <= ACCMAX))
		else $error("blend accumulator above full scale");

	a_result_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == S_OUT))
		else $error("result raised outside output state");

	a_write_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> ($past(state_q) == S_IDLE))
		else $error("texel write not started from idle");

endmodule

[test/texture_sampler_bilinear_wrap_top_tb.sv]
`timescale 1ns / 1ps

module texture_sampler_bilinear_wrap_top_tb;
	import tsbw_pkg::*;

	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int FRAC = TSBW_COORD_FRAC_BITS;
	localparam int CAP = TSBW_TEXEL_CAPACITY;
	localparam int DRAIN_CYCLES = 400;       // > longest item latency
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int LONG_HOLD = 300;

	// Predicts sampled colors from its own copy of the texel store and sizes.
	class tex_scoreboard;
		bit [23:0] store[CAP];
		bit planned[CAP];                 // entries the stimulus has written (or will)
		bit [SIZE_W-1:0] width_reg, height_reg;
		logic [23:0] pending_rgb[$];
		int errors, samples, writes;

		function new();
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
		endfunction

		function void set_reg(int idx, bit [SIZE_W-1:0] val);
			if (idx == REG_TEX_WIDTH) width_reg = val;
			else if (idx == REG_TEX_HEIGHT) height_reg = val;
		endfunction

		function longint dim(bit [SIZE_W-1:0] r);
			return (r == 0) ? 1 : longint'(r);
		endfunction

		function longint fix_floor(longint s);
			if (s >= 0) return s >>> FRAC;
			return -((-s + (longint'(1) << FRAC) - 1) >>> FRAC);
		endfunction

		function longint fix_round(longint s);
			longint half;
			half = longint'(1) << (FRAC - 1);
			if (s >= 0) return (s + half) >>> FRAC;
			return -((-s + half) >>> FRAC);
		endfunction

		function longint wrap(longint a, longint n);
			longint m;
			m = a % n;
			if (m < 0) m += n;
			return m;
		endfunction

		function int unsigned texel_addr(longint col, longint row);
			longint w, h;
			w = dim(width_reg);
			h = dim(height_reg);
			return int'((wrap(row, h) * w + wrap(col, w)) % CAP);
		endfunction

		// Store addresses a sample reads: one for nearest, ff/fc/cf/cc for bilinear.
		function void texel_addrs(bit [1:0] mode, longint u, longint v,
				ref int unsigned a[$]);
			longint sx, sy, cf, cc, yf, rf, rc;
			a.delete();
			sx = u * dim(width_reg);
			sy = v * dim(height_reg);
			if (mode == MODE_NEAREST) begin
				a.push_back(texel_addr(fix_round(sx), fix_round(-sy)));
			end else if (mode == MODE_BILINEAR) begin
				cf = fix_floor(sx);
				cc = cf + ((sx & 16'hFFFF) != 0);
				yf = fix_floor(sy);
				rf = -yf;
				rc = -(yf + ((sy & 16'hFFFF) != 0));
				a.push_back(texel_addr(cf, rf));
				a.push_back(texel_addr(cf, rc));
				a.push_back(texel_addr(cc, rf));
				a.push_back(texel_addr(cc, rc));
			end
		endfunction

		function void note_input(bit [1:0] mode, bit [87:0] d);
			int unsigned a[$];
			longint u, v, sx, sy, fx, fy, wxf, wxc, wyf, wyc, acc;
			logic [23:0] rgb;
			u = longint'($signed(d[63:40]));
			v = longint'($signed(d[87:64]));
			if (mode == MODE_WRITE) begin
				store[d[15:0]] = d[39:16];
				writes++;
				return;
			end
			if (mode != MODE_NEAREST && mode != MODE_BILINEAR) return;
			texel_addrs(mode, u, v, a);
			samples++;
			if (mode == MODE_NEAREST) begin
				pending_rgb.push_back(store[a[0]]);
				return;
			end
			sx = u * dim(width_reg);
			sy = v * dim(height_reg);
			fx = sx & 16'hFFFF;
			fy = sy & 16'hFFFF;
			wxf = fx ? (longint'(1) << FRAC) - fx : 0;
			wxc = (longint'(1) << FRAC) - wxf;
			wyf = fy ? (longint'(1) << FRAC) - fy : 0;
			wyc = (longint'(1) << FRAC) - wyf;
			for (int k = 0; k < 3; k++) begin
				acc = (longint'(store[a[0]][8*k +: 8]) * wyf +
					longint'(store[a[1]][8*k +: 8]) * wyc) * wxf +
					(longint'(store[a[2]][8*k +: 8]) * wyf +
					longint'(store[a[3]][8*k +: 8]) * wyc) * wxc;
				acc = (acc + (longint'(1) << (2*FRAC - 1))) >>> (2*FRAC);
				rgb[8*k +: 8] = (acc > 255) ? 8'd255 : acc[7:0];
			end
			pending_rgb.push_back(rgb);
		endfunction

		function void check_result(logic [23:0] got);
			logic [23:0] exp_rgb;
			if (pending_rgb.size() == 0) begin
				$error("unexpected result transaction %h", got);
				errors++;
				return;
			end
			exp_rgb = pending_rgb.pop_front();
			if (got[7:0] !== exp_rgb[7:0]) begin
				$error("out_red expected %0d actual %0d", exp_rgb[7:0], got[7:0]);
				errors++;
			end
			if (got[15:8] !== exp_rgb[15:8]) begin
				$error("out_green expected %0d actual %0d", exp_rgb[15:8], got[15:8]);
				errors++;
			end
			if (got[23:16] !== exp_rgb[23:16]) begin
				$error("out_blue expected %0d actual %0d", exp_rgb[23:16], got[23:16]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic [MODE_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SIZE_W-1:0] cfg_data = '0;

	tex_scoreboard tex_sb = new();
	bit calm;        // no idling on either side
	bit long_hold;   // receiver holds off for a long stretch
	longint cycles;
	int phases;
	int sent;        // input transactions accepted so far

	texture_sampler_bilinear_wrap_top i_dut (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Monitors: inputs feed the predictor, outputs are checked against it.
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			tex_sb.note_input(s_axis_tuser, s_axis_tdata);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tex_sb.check_result(m_axis_tdata);
	end

	// Receiver: random stalls per transaction, and one long hold-off when long_hold is set.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 0;
			end
			n = calm ? 0 : $urandom_range(0, 3);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// One input transaction; valid stays up into the next one when no gap is drawn.
	task automatic send_item(logic [MODE_W-1:0] mode, logic [87:0] d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_write(int unsigned idx, logic [23:0] rgb);
		tex_sb.planned[idx[15:0]] = 1'b1;
		send_item(MODE_WRITE, {48'd0, rgb, idx[15:0]});
	endtask

	// Writes any texel the sample would read that was never written, then samples.
	task automatic send_sample(logic [MODE_W-1:0] mode, logic [23:0] u, logic [23:0] v);
		int unsigned a[$];
		tex_sb.texel_addrs(mode, longint'($signed(u)), longint'($signed(v)), a);
		foreach (a[i])
			if (!tex_sb.planned[a[i]])
				send_write(a[i], 24'($urandom));
		send_item(mode, {v, u, 24'($urandom), 16'($urandom)});
	endtask

	// Size change only once the block is idle: results drained, last write done.
	task automatic program_size(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h, bit stray);
		s_axis_tvalid <= 1'b0;
		while (tex_sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_TEX_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		tex_sb.set_reg(REG_TEX_WIDTH, w);
		cfg_index <= REG_TEX_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		tex_sb.set_reg(REG_TEX_HEIGHT, h);
		if (stray) begin
			// indexes beyond the register map must not disturb anything
			cfg_index <= CFG_IDX_W'(2);
			cfg_data <= 11'h7FF;
			@(posedge clk);
			cfg_index <= CFG_IDX_W'(3);
			cfg_data <= 11'd0;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic logic [23:0] rand_coord();
		case ($urandom_range(0, 5))
			0, 1: return 24'($urandom);
			2: return 24'($signed($urandom_range(0, 262144)) - 131072);
			3: return 24'(($signed($urandom_range(0, 16)) - 8) <<< FRAC);   // exact integers
			4: return 24'(($signed($urandom_range(0, 64)) - 32) <<< (FRAC - 1)); // halves
			default: return 24'($signed($urandom_range(0, 1024)) - 512);
		endcase
	endfunction

	// Sends about count transactions, texel fills for samples included.
	task automatic random_items(int count);
		int r;
		int stop;
		stop = sent + count;
		while (sent < stop) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				send_write($urandom_range(0, CAP - 1), 24'($urandom));
			else if (r < 18)
				send_item(MODE_UNUSED, 88'({$urandom, $urandom, $urandom}));
			else
				send_sample((r < 55) ? MODE_NEAREST : MODE_BILINEAR,
					rand_coord(), rand_coord());
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset sizes, extreme fields, each mode, mode 3 ignored.
		send_write(0, 24'h000000);
		send_write(CAP - 1, 24'hFFFFFF);
		send_item(MODE_UNUSED, {88{1'b1}});
		send_sample(MODE_NEAREST, 24'd0, 24'd0);
		send_sample(MODE_BILINEAR, 24'd0, 24'd0);
		send_sample(MODE_NEAREST, 24'h7FFFFF, 24'h800000);
		send_sample(MODE_BILINEAR, 24'h7FFFFF, 24'h800000);
		send_sample(MODE_BILINEAR, 24'h800000, 24'h7FFFFF);
		send_sample(MODE_NEAREST, 24'h000080, 24'hFFFF80); // rounds half away from zero
		send_sample(MODE_BILINEAR, 24'h008000, 24'hFF8000);
		send_sample(MODE_BILINEAR, 24'h000001, 24'hFFFFFF);
		send_sample(MODE_NEAREST, 24'hFF0000, 24'h010000);

		program_size(11'd1, 11'd1, 1'b1);
		random_items(150);
		program_size(11'd0, 11'd0, 1'b0);       // zero size acts as one
		random_items(100);
		program_size(11'd1024, 11'd1024, 1'b0);
		long_hold = 1;                           // sender keeps offering during hold
		random_items(200);
		program_size(11'h7FF, 11'd3, 1'b0);     // oversized width used as given
		calm = 1;
		random_items(150);
		calm = 0;
		program_size(11'd5, 11'd1024, 1'b1);
		random_items(200);
		program_size(11'd7, 11'd13, 1'b0);
		random_items(200);
		program_size(11'($urandom_range(1, 64)), 11'($urandom_range(1, 64)), 1'b0);
		random_items(150);
		program_size(11'd256, 11'd256, 1'b0);
		random_items(150);

		s_axis_tvalid <= 1'b0;
		while (tex_sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d texel writes and %0d samples over %0d size settings,",
			tex_sb.writes, tex_sb.samples, phases + 1);
		$display("including long output stalls, zero and oversized sizes.");
		if (tex_sb.errors == 0 && tex_sb.pending_rgb.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
